### rtl/core/switch_matrix_latch_scanner_top_defines.svh
// Assertion macros for the switch matrix latch scanner.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SWITCH_MATRIX_LATCH_SCANNER_TOP_DEFINES_SVH
`define SWITCH_MATRIX_LATCH_SCANNER_TOP_DEFINES_SVH

// same-cycle implication
`define SMLS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("switch matrix scanner check failed");

// next-cycle implication
`define SMLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("switch matrix scanner check failed");

`endif

### rtl/core/smls_pkg.sv
// Shared types and constants for the switch matrix latch scanner.
// No dependencies.
package smls_pkg;

    localparam logic [2:0] OP_STROBE       = 3'd0;
    localparam logic [2:0] OP_CLEAR_ALL    = 3'd1;
    localparam logic [2:0] OP_CLEAR_SWITCH = 3'd2;
    localparam logic [2:0] OP_QUERY        = 3'd3;
    localparam logic [2:0] OP_QUERY_ONCE   = 3'd4;
    localparam logic [2:0] OP_REGISTER     = 3'd5;

    localparam logic [7:0] ALL_ONES      = 8'hFF;
    localparam logic [3:0] COUNTER_IDLE  = 4'd15;
    localparam logic [3:0] ROW_COUNT     = 4'd8;
    localparam logic [3:0] SCANNED_RESET = 4'd8;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOOKUP,
        ST_BLOCK,
        ST_TEST,
        ST_EVENT,
        ST_BLOCK_WR,
        ST_FINAL
    } smls_state_t;

    typedef struct packed {
        logic       valid;
        logic       sw_state;
        logic       ev_valid;
        logic [7:0] number;
        logic       last;
    } smls_result_t;

endpackage

### rtl/core/smls_out_stage.sv
// Result output register for the switch matrix latch scanner.
// Depends on smls_pkg (smls_result_t, OUT_DATA_W).
module smls_out_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  smls_pkg::smls_result_t            result,
    output logic                              free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: switch_state[0], event_number[8:1], zero fill
    output logic [smls_pkg::OUT_DATA_W-1:0]   m_tdata,
    // m_tuser: event_valid[0]
    output logic                              m_tuser,
    output logic                              m_tlast
);

    logic                   valid_reg;
    logic                   valid_next;
    smls_pkg::smls_result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && result.valid)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(smls_pkg::OUT_DATA_W - 9){1'b0}}, data_reg.number, data_reg.sw_state};
    assign m_tuser  = data_reg.ev_valid;
    assign m_tlast  = data_reg.last;

endmodule

### rtl/core/switch_matrix_latch_scanner_top.sv
// Switch matrix latch scanner: 8x8 latch array, registration and block tables.
// Depends on smls_pkg, smls_out_stage and the assertion macro header.
//
// One request at a time. Strobe, clear and register requests pass through
// accept, execute and final result. A query adds a latch test step; a query
// by number adds a lookup through the registration table, a query once adds
// a block table search, and a latched switch adds an event scan over the
// registrations and, for a query once, a block entry write. Each table memory
// has a single read port, walked one entry per cycle, though the event scan
// holds on a matching entry and the final result waits while the result channel stalls.
// No clearing pass after reset: block entries carry valid bits and the
// registration table is read only below its fill count.
`include "switch_matrix_latch_scanner_top_defines.svh"

module switch_matrix_latch_scanner_top
#(
    parameter int MAX_REGISTERED = 32,
    parameter int MAX_BLOCKED    = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [3:0]                        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: reset_strobe[0], return_lines[8:1], row[12:9], column[16:13],
    //          switch_number[24:17], by_number[25], hold_ms[40:26],
    //          now_ms[72:41], zero fill
    input  logic [smls_pkg::IN_DATA_W-1:0]    s_tdata,
    // s_tuser: operation[2:0]
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: switch_state[0], event_number[8:1], zero fill
    output logic [smls_pkg::OUT_DATA_W-1:0]   m_tdata,
    // m_tuser: event_valid[0]
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int RA = (MAX_REGISTERED > 1) ? $clog2(MAX_REGISTERED) : 1;
    localparam int CW = $clog2(MAX_REGISTERED + 1);
    localparam int BA = (MAX_BLOCKED > 1) ? $clog2(MAX_BLOCKED) : 1;

    // captured request
    logic [2:0]  op_reg;
    logic        rstb_reg;
    logic [7:0]  ret_reg;
    logic [3:0]  row_reg;
    logic [3:0]  col_reg;
    logic [7:0]  num_reg;
    logic        bynum_reg;
    logic [14:0] hold_reg;
    logic [31:0] now_reg;

    smls_pkg::smls_state_t state_reg, state_next;
    logic [3:0]  scanned_rows_reg;
    logic [63:0] latch_reg, latch_next;
    logic [3:0]  counter_reg, counter_next;
    logic [CW-1:0] map_count_reg, map_count_next;
    logic [RA-1:0] idx_reg, idx_next, idx_inc;
    logic [CW-1:0] idx_plus;
    logic [BA-1:0] bidx_reg, bidx_next, bidx_inc;
    logic [BA-1:0] ring_reg, ring_next;
    logic [5:0]  pos_reg, pos_next;
    logic        res_state_reg, res_state_next;
    logic [MAX_BLOCKED-1:0] blk_valid_reg;

    // registration table
    logic [5:0]  map_pos_mem [MAX_REGISTERED];
    logic [7:0]  map_num_mem [MAX_REGISTERED];
    logic [5:0]  map_pos_rd_reg;
    logic [7:0]  map_num_rd_reg;
    logic [RA-1:0] map_raddr;
    logic        map_we;

    // block table
    logic [5:0]  blk_pos_mem [MAX_BLOCKED];
    logic [31:0] blk_until_mem [MAX_BLOCKED];
    logic [5:0]  blk_pos_rd_reg;
    logic [31:0] blk_until_rd_reg;
    logic [BA-1:0] blk_raddr;
    logic        blk_we;
    logic        blk_clr;

    logic [3:0]  strobe_col;
    logic [3:0]  strobe_limit;
    logic [3:0]  row_m1;
    logic [3:0]  col_m1;
    logic        pos_ok;
    logic [5:0]  pos_in;
    logic        once;
    logic        out_free;
    smls_pkg::smls_result_t emit;

    assign row_m1   = row_reg - 4'd1;
    assign col_m1   = col_reg - 4'd1;
    assign pos_ok   = (row_reg >= 4'd1) && (row_reg <= smls_pkg::ROW_COUNT) &&
                      (col_reg >= 4'd1) && (col_reg <= smls_pkg::ROW_COUNT);
    assign pos_in   = {row_m1[2:0], col_m1[2:0]};
    assign once     = (op_reg == smls_pkg::OP_QUERY_ONCE);
    assign idx_inc  = idx_reg + RA'(1);
    assign idx_plus = CW'(idx_reg) + CW'(1);
    assign bidx_inc = bidx_reg + BA'(1);
    assign strobe_col   = rstb_reg ? 4'd0 : counter_reg;
    assign strobe_limit = (scanned_rows_reg > smls_pkg::ROW_COUNT) ?
                          smls_pkg::ROW_COUNT : scanned_rows_reg;

    always_comb
    begin
        state_next     = state_reg;
        latch_next     = latch_reg;
        counter_next   = counter_reg;
        map_count_next = map_count_reg;
        idx_next       = idx_reg;
        bidx_next      = bidx_reg;
        ring_next      = ring_reg;
        pos_next       = pos_reg;
        res_state_next = res_state_reg;
        map_we         = 1'b0;
        map_raddr      = '0;
        blk_raddr      = '0;
        blk_we         = 1'b0;
        blk_clr        = 1'b0;
        emit           = '0;
        s_tready       = 1'b0;

        case (state_reg)
            smls_pkg::ST_IDLE:
            begin
                s_tready       = 1'b1;
                res_state_next = 1'b0;
                if (s_tvalid)
                begin
                    state_next = smls_pkg::ST_EXEC;
                end
            end

            smls_pkg::ST_EXEC:
            begin
                state_next = smls_pkg::ST_FINAL;
                idx_next   = '0;
                bidx_next  = '0;
                case (op_reg)
                    smls_pkg::OP_STROBE:
                    begin
                        counter_next = strobe_col;
                        if (strobe_col < strobe_limit)
                        begin
                            latch_next[{strobe_col[2:0], 3'b000} +: 8] =
                                latch_reg[{strobe_col[2:0], 3'b000} +: 8] |
                                (ret_reg ^ smls_pkg::ALL_ONES);
                            counter_next = strobe_col + 4'd1;
                        end
                    end

                    smls_pkg::OP_CLEAR_ALL:
                    begin
                        latch_next   = '0;
                        counter_next = smls_pkg::COUNTER_IDLE;
                    end

                    smls_pkg::OP_CLEAR_SWITCH:
                    begin
                        if (pos_ok)
                        begin
                            latch_next[pos_in] = 1'b0;
                        end
                    end

                    smls_pkg::OP_REGISTER:
                    begin
                        if (pos_ok && (map_count_reg < CW'(MAX_REGISTERED)))
                        begin
                            map_we         = 1'b1;
                            map_count_next = map_count_reg + CW'(1);
                        end
                    end

                    smls_pkg::OP_QUERY, smls_pkg::OP_QUERY_ONCE:
                    begin
                        if (bynum_reg)
                        begin
                            if (map_count_reg != '0)
                            begin
                                state_next = smls_pkg::ST_LOOKUP;
                            end
                        end
                        else if (pos_ok)
                        begin
                            pos_next   = pos_in;
                            state_next = once ? smls_pkg::ST_BLOCK : smls_pkg::ST_TEST;
                        end
                    end

                    default:
                    begin
                        state_next = smls_pkg::ST_FINAL;
                    end
                endcase
            end

            smls_pkg::ST_LOOKUP:
            begin
                map_raddr = idx_reg;
                if (map_num_rd_reg == num_reg)
                begin
                    pos_next   = map_pos_rd_reg;
                    state_next = once ? smls_pkg::ST_BLOCK : smls_pkg::ST_TEST;
                end
                else if (idx_plus == map_count_reg)
                begin
                    state_next = smls_pkg::ST_FINAL;
                end
                else
                begin
                    idx_next  = idx_inc;
                    map_raddr = idx_inc;
                end
            end

            smls_pkg::ST_BLOCK:
            begin
                blk_raddr = bidx_reg;
                if (blk_valid_reg[bidx_reg] && (blk_pos_rd_reg == pos_reg))
                begin
                    if (blk_until_rd_reg > now_reg)
                    begin
                        state_next = smls_pkg::ST_FINAL;
                    end
                    else
                    begin
                        blk_clr    = 1'b1;
                        state_next = smls_pkg::ST_TEST;
                    end
                end
                else if (bidx_reg == BA'(MAX_BLOCKED - 1))
                begin
                    state_next = smls_pkg::ST_TEST;
                end
                else
                begin
                    bidx_next = bidx_inc;
                    blk_raddr = bidx_inc;
                end
            end

            smls_pkg::ST_TEST:
            begin
                idx_next = '0;
                if (!latch_reg[pos_reg])
                begin
                    state_next = smls_pkg::ST_FINAL;
                end
                else
                begin
                    res_state_next = 1'b1;
                    if (map_count_reg == '0)
                    begin
                        state_next = once ? smls_pkg::ST_BLOCK_WR : smls_pkg::ST_FINAL;
                    end
                    else
                    begin
                        state_next = smls_pkg::ST_EVENT;
                    end
                end
            end

            smls_pkg::ST_EVENT:
            begin
                map_raddr = idx_reg;
                if ((map_pos_rd_reg != pos_reg) || out_free)
                begin
                    if (map_pos_rd_reg == pos_reg)
                    begin
                        emit.valid    = 1'b1;
                        emit.ev_valid = 1'b1;
                        emit.number   = map_num_rd_reg;
                    end
                    if (idx_plus == map_count_reg)
                    begin
                        state_next = once ? smls_pkg::ST_BLOCK_WR : smls_pkg::ST_FINAL;
                    end
                    else
                    begin
                        idx_next  = idx_inc;
                        map_raddr = idx_inc;
                    end
                end
            end

            smls_pkg::ST_BLOCK_WR:
            begin
                blk_we     = 1'b1;
                ring_next  = (ring_reg == BA'(MAX_BLOCKED - 1)) ? '0 : ring_reg + BA'(1);
                state_next = smls_pkg::ST_FINAL;
            end

            smls_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    emit.valid    = 1'b1;
                    emit.sw_state = res_state_reg;
                    emit.last     = 1'b1;
                    state_next    = smls_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = smls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= smls_pkg::ST_IDLE;
            scanned_rows_reg <= smls_pkg::SCANNED_RESET;
            latch_reg        <= '0;
            counter_reg      <= smls_pkg::COUNTER_IDLE;
            map_count_reg    <= '0;
            idx_reg          <= '0;
            bidx_reg         <= '0;
            ring_reg         <= '0;
            pos_reg          <= '0;
            res_state_reg    <= 1'b0;
            blk_valid_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            latch_reg     <= latch_next;
            counter_reg   <= counter_next;
            map_count_reg <= map_count_next;
            idx_reg       <= idx_next;
            bidx_reg      <= bidx_next;
            ring_reg      <= ring_next;
            pos_reg       <= pos_next;
            res_state_reg <= res_state_next;
            if (cfg_we)
            begin
                scanned_rows_reg <= cfg_wdata;
            end
            if (blk_clr)
            begin
                blk_valid_reg[bidx_reg] <= 1'b0;
            end
            if (blk_we)
            begin
                blk_valid_reg[ring_next] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tuser;
            rstb_reg  <= s_tdata[0];
            ret_reg   <= s_tdata[8:1];
            row_reg   <= s_tdata[12:9];
            col_reg   <= s_tdata[16:13];
            num_reg   <= s_tdata[24:17];
            bynum_reg <= s_tdata[25];
            hold_reg  <= s_tdata[40:26];
            now_reg   <= s_tdata[72:41];
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_pos_mem[map_count_reg[RA-1:0]] <= pos_in;
            map_num_mem[map_count_reg[RA-1:0]] <= num_reg;
        end
        map_pos_rd_reg <= map_pos_mem[map_raddr];
        map_num_rd_reg <= map_num_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_pos_mem[ring_next]   <= pos_reg;
            blk_until_mem[ring_next] <= now_reg + {17'd0, hold_reg};
        end
        blk_pos_rd_reg   <= blk_pos_mem[blk_raddr];
        blk_until_rd_reg <= blk_until_mem[blk_raddr];
    end

    smls_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (emit),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `SMLS_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready)
    `SMLS_ASSERT_IMPL(a_event_not_last, m_tvalid && m_tuser, !m_tlast && !m_tdata[0])
    `SMLS_ASSERT_IMPL(a_count_bound, 1'b1, map_count_reg <= CW'(MAX_REGISTERED))
    `SMLS_ASSERT_IMPL(a_counter_range, 1'b1, (counter_reg == smls_pkg::COUNTER_IDLE) || (counter_reg <= smls_pkg::ROW_COUNT))

endmodule
